/* design/grammar_rule_tokenizer_top_assert.svh */
// Assertion macros for the grammar rule tokenizer checker.
// Included by the checker file; holds macro definitions only.
`ifndef GRAMMAR_RULE_TOKENIZER_TOP_ASSERT_SVH
`define GRAMMAR_RULE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grammar rule tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grammar rule tokenizer check failed");

`endif

/* design/grt_pkg.sv */
// Shared types, codes and helpers of the grammar rule tokenizer.
// No dependencies; used by every other file of the block but the assertion macro header.
package grt_pkg;

	// Default bound on the length of one captured symbol.
	localparam int GRT_MAX_SYMBOL_LEN = 255;

	// Result queue depth (a power of two) and its pointer width.
	localparam int GRT_QDEPTH = 4;
	localparam int GRT_QAW    = $clog2(GRT_QDEPTH);

	// Characters with a meaning in the grammar text.
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;

	// Parse state, one-hot.
	typedef enum logic [8:0] {
		ST_INITIAL    = 9'b000000001,
		ST_RULE       = 9'b000000010,
		ST_WAIT_EQ    = 9'b000000100,
		ST_BEGIN_COMP = 9'b000001000,
		ST_TERM       = 9'b000010000,
		ST_NONTERM    = 9'b000100000,
		ST_END_COMP   = 9'b001000000,
		ST_DONE       = 9'b010000000,
		ST_ERROR      = 9'b100000000
	} grt_state_t;

	// Event codes as seen on the result port.
	typedef enum logic [2:0] {
		EV_RULE_CHAR = 3'd0,
		EV_RULE_END  = 3'd1,
		EV_TERM_CHAR = 3'd2,
		EV_TERM_END  = 3'd3,
		EV_NT_CHAR   = 3'd4,
		EV_NT_END    = 3'd5,
		EV_DONE      = 3'd6,
		EV_ERROR     = 3'd7
	} grt_kind_t;

	// One result item.
	typedef struct packed {
		grt_kind_t   kind;
		logic [7:0]  chr;
		logic [15:0] rn;
		logic        last;
	} grt_event_t;

	// All results caused by one input item (cnt is 0, 1 or 2).
	typedef struct packed {
		logic [1:0] cnt;
		grt_event_t ev0;
		grt_event_t ev1;
	} grt_res_t;

	// Space, tab, newline, vertical tab, form feed, carriage return.
	function automatic logic grt_is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
	endfunction

	// Digits and ASCII letters.
	function automatic logic grt_is_alnum(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	// Builds a result item; the last flag is filled in later.
	function automatic grt_event_t grt_mk_event(input grt_kind_t kind, input logic [7:0] chr,
			input logic [15:0] rn);
		grt_event_t ev;
		ev.kind = kind;
		ev.chr  = chr;
		ev.rn   = rn;
		ev.last = 1'b0;
		return ev;
	endfunction

endpackage

/* design/grammar_rule_tokenizer_top.sv */
// Top level of the grammar rule tokenizer: input register, parse state,
// step logic and result queue. Depends on grt_pkg, grt_step and grt_resq.
//
// channel   direction  handshake                 payload
// char      in         char_valid / char_stall   char_code, end_of_input
// event     out        event_valid / event_stall event_kind, symbol_char,
//                                                 rule_number, last_of_run
//
// One character is taken every cycle while char_stall is low; the step logic
// works on a character in the cycle after the edge that registers it, and its
// results are registered in the result queue before they reach the event port.
// A rule-name close that fails yields two results, which drain from the
// four-entry result queue one per cycle while event_stall is low.
// char_stall rises only while the input register holds a character and the
// queue lacks room for two results. Reset puts the parser in its initial
// state with the symbol length and rule counter at zero.
module grammar_rule_tokenizer_top #(
	parameter int MAX_SYMBOL_LEN = grt_pkg::GRT_MAX_SYMBOL_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  symbol_char,
	output logic [15:0] rule_number,
	output logic        last_of_run
);
	import grt_pkg::*;

	localparam int LEN_W = $clog2(MAX_SYMBOL_LEN + 1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eof_s1;
	grt_state_t       state_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      ctr_q;
	grt_state_t       nstate;
	logic [LEN_W-1:0] nlen;
	logic [15:0]      nctr;
	grt_res_t         step_res;
	grt_res_t         push;
	logic             room;
	logic             advance;
	logic             accept;
	logic             pop;
	grt_event_t       head;

	// Handshakes.
	assign advance    = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign accept     = char_valid && !char_stall;
	assign pop        = event_valid && !event_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eof_s1  <= end_of_input;
		end
	end

	// Step logic for the registered character.
	grt_step #(
		.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN)
	) u_step (
		.state  (state_q),
		.len    (len_q),
		.ctr    (ctr_q),
		.chr    (char_s1),
		.eof    (eof_s1),
		.nstate (nstate),
		.nlen   (nlen),
		.nctr   (nctr),
		.res    (step_res)
	);

	// Parse state, symbol length and rule counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INITIAL;
			len_q   <= '0;
			ctr_q   <= '0;
		end else if (advance) begin
			state_q <= nstate;
			len_q   <= nlen;
			ctr_q   <= nctr;
		end
	end

	// Results enter the queue only when the character is consumed.
	always_comb begin
		push     = step_res;
		push.cnt = advance ? step_res.cnt : 2'd0;
	end

	grt_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (event_valid),
		.head      (head)
	);

	// Result port.
	assign event_kind  = head.kind;
	assign symbol_char = head.chr;
	assign rule_number = head.rn;
	assign last_of_run = head.last;

endmodule

/* design/grt_step.sv */
// Next-state and event logic for one character of grammar text.
// Purely combinational; depends on grt_pkg.
module grt_step #(
	parameter int MAX_SYMBOL_LEN = grt_pkg::GRT_MAX_SYMBOL_LEN
) (
	input  grt_pkg::grt_state_t                   state,
	input  logic [$clog2(MAX_SYMBOL_LEN+1)-1:0]   len,
	input  logic [15:0]                           ctr,
	input  logic [7:0]                            chr,
	input  logic                                  eof,
	output grt_pkg::grt_state_t                   nstate,
	output logic [$clog2(MAX_SYMBOL_LEN+1)-1:0]   nlen,
	output logic [15:0]                           nctr,
	output grt_pkg::grt_res_t                     res
);
	import grt_pkg::*;

	localparam int LEN_W = $clog2(MAX_SYMBOL_LEN + 1);

	logic        c_ws;
	logic        c_alnum;
	logic        c_lt;
	logic        c_gt;
	logic        c_eq;
	logic        c_sp;
	logic        c_lf;
	logic        c_cr;
	logic [15:0] ctr_sat;
	logic        app_ok;
	logic        do_app;
	grt_kind_t   app_kind;
	logic [1:0]  cnt;
	grt_event_t  ev0;
	grt_event_t  ev1;

	// Character classes; none of them holds at end of input.
	assign c_ws    = !eof && grt_is_ws(chr);
	assign c_alnum = !eof && grt_is_alnum(chr);
	assign c_lt    = !eof && (chr == CH_LT);
	assign c_gt    = !eof && (chr == CH_GT);
	assign c_eq    = !eof && (chr == CH_EQ);
	assign c_sp    = !eof && (chr == CH_SP);
	assign c_lf    = !eof && (chr == CH_LF);
	assign c_cr    = !eof && (chr == CH_CR);

	// Saturating rule count and the symbol length bound.
	assign ctr_sat = (ctr == 16'hFFFF) ? ctr : ctr + 16'd1;
	assign app_ok  = len < LEN_W'(MAX_SYMBOL_LEN);

	// State transition. A component start that is not '<' and a newline that
	// ends a terminal are folded into the state they lead to.
	always_comb begin
		nstate   = state;
		nlen     = len;
		nctr     = ctr;
		cnt      = 2'd0;
		ev0      = grt_mk_event(EV_ERROR, 8'h00, ctr);
		ev1      = grt_mk_event(EV_ERROR, 8'h00, ctr);
		do_app   = 1'b0;
		app_kind = EV_TERM_CHAR;
		unique case (state)
			ST_INITIAL: begin
				if (eof) begin
					nstate = ST_DONE;
					cnt    = 2'd1;
					ev0    = grt_mk_event(EV_DONE, 8'h00, ctr);
				end else if (c_ws) begin
					nstate = state;
				end else if (c_lt) begin
					nstate = ST_RULE;
				end else begin
					nstate = ST_ERROR;
					cnt    = 2'd1;
				end
			end
			ST_RULE: begin
				if (c_ws) begin
					nstate = state;
				end else if (c_alnum) begin
					do_app   = 1'b1;
					app_kind = EV_RULE_CHAR;
				end else if (c_gt) begin
					nstate = ST_WAIT_EQ;
				end else begin
					nstate = ST_ERROR;
					cnt    = 2'd1;
				end
			end
			ST_WAIT_EQ: begin
				if (!c_ws) begin
					nctr = ctr_sat;
					nlen = '0;
					cnt  = 2'd1;
					ev0  = grt_mk_event(EV_RULE_END, 8'h00, ctr_sat);
					if (c_eq) begin
						nstate = ST_BEGIN_COMP;
					end else begin
						nstate = ST_ERROR;
						cnt    = 2'd2;
						ev1    = grt_mk_event(EV_ERROR, 8'h00, ctr_sat);
					end
				end
			end
			ST_BEGIN_COMP: begin
				if (eof) begin
					nstate = ST_ERROR;
					cnt    = 2'd1;
				end else if (c_ws) begin
					nstate = state;
				end else if (c_lt) begin
					nstate = ST_NONTERM;
				end else begin
					nstate = ST_TERM;
					do_app = 1'b1;
				end
			end
			ST_TERM: begin
				if (eof) begin
					nstate = ST_ERROR;
					cnt    = 2'd1;
				end else if (c_sp && (len == '0)) begin
					nstate = state;
				end else if (c_ws) begin
					nstate = c_lf ? ST_INITIAL : ST_END_COMP;
					nlen   = '0;
					cnt    = 2'd1;
					ev0    = grt_mk_event(EV_TERM_END, 8'h00, ctr);
				end else begin
					do_app = 1'b1;
				end
			end
			ST_NONTERM: begin
				if (c_ws) begin
					nstate = state;
				end else if (c_alnum) begin
					do_app   = 1'b1;
					app_kind = EV_NT_CHAR;
				end else if (c_gt) begin
					nstate = ST_END_COMP;
					nlen   = '0;
					cnt    = 2'd1;
					ev0    = grt_mk_event(EV_NT_END, 8'h00, ctr);
				end else begin
					nstate = ST_ERROR;
					cnt    = 2'd1;
				end
			end
			ST_END_COMP: begin
				if (eof) begin
					nstate = ST_DONE;
					cnt    = 2'd1;
					ev0    = grt_mk_event(EV_DONE, 8'h00, ctr);
				end else if (c_sp) begin
					nstate = state;
				end else if (c_cr || c_lf) begin
					nstate = ST_INITIAL;
				end else if (c_lt) begin
					nstate = ST_NONTERM;
				end else if (c_ws) begin
					// Tab, vertical tab or form feed closes an empty terminal.
					nstate = ST_END_COMP;
					nlen   = '0;
					cnt    = 2'd1;
					ev0    = grt_mk_event(EV_TERM_END, 8'h00, ctr);
				end else begin
					nstate = ST_TERM;
					do_app = 1'b1;
				end
			end
			ST_DONE: begin
				cnt = 2'd1;
				ev0 = grt_mk_event(EV_DONE, 8'h00, ctr);
			end
			ST_ERROR: begin
				cnt = 2'd1;
			end
			default: begin
				nstate = ST_ERROR;
				cnt    = 2'd1;
			end
		endcase

		// Appending a character, or an error when the symbol is full.
		if (do_app) begin
			cnt = 2'd1;
			if (!app_ok) begin
				nstate = ST_ERROR;
			end else begin
				nlen = len + LEN_W'(1);
				ev0  = grt_mk_event(app_kind, chr, (app_kind == EV_RULE_CHAR) ? ctr_sat : ctr);
			end
		end

		ev0.last = (cnt == 2'd1);
		ev1.last = 1'b1;
		res.cnt  = cnt;
		res.ev0  = ev0;
		res.ev1  = ev1;
	end

endmodule

/* design/grt_resq.sv */
// Small result queue: takes up to two items a cycle, gives one.
// Depends on grt_pkg for the item type and the depth.
module grt_resq (
	input  logic                clk,
	input  logic                arst_n,
	input  grt_pkg::grt_res_t   push,
	input  logic                pop,
	output logic                room,
	output logic                not_empty,
	output grt_pkg::grt_event_t head
);
	import grt_pkg::*;

	grt_event_t           mem_q [GRT_QDEPTH];
	logic [GRT_QAW-1:0]   wr_q;
	logic [GRT_QAW-1:0]   rd_q;
	logic [GRT_QAW:0]     cnt_q;
	logic [GRT_QAW-1:0]   wr_next;

	assign wr_next = wr_q + GRT_QAW'(1);

	// Room for a full pair of results, regardless of this cycle's pop.
	assign room      = cnt_q <= (GRT_QAW+1)'(GRT_QDEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	// Item storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.ev0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.ev1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + GRT_QAW'(push.cnt);
			rd_q  <= rd_q + GRT_QAW'(pop);
			cnt_q <= cnt_q + (GRT_QAW+1)'(push.cnt) - (GRT_QAW+1)'(pop);
		end
	end

endmodule

/* design/grt_checker.sv */
// Port-level checks of the grammar rule tokenizer, bound to its top level.
// Depends on grt_pkg and the assertion macro header.
`include "grammar_rule_tokenizer_top_assert.svh"

module grt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic [7:0]  char_code,
	input logic        end_of_input,
	input logic        event_valid,
	input logic        event_stall,
	input logic [2:0]  event_kind,
	input logic [7:0]  symbol_char,
	input logic [15:0] rule_number,
	input logic        last_of_run
);
	import grt_pkg::*;

	logic ev_take;
	logic ev_held;
	logic no_char;

	assign ev_take = event_valid && !event_stall;
	assign ev_held = event_valid && !event_stall == 1'b0 && event_valid;
	assign no_char = event_kind[0] || (event_kind == EV_DONE);

	// A stalled result item holds its kind and payload.
	`GRT_ASSERT_NXT(a_stall_hold, clk, arst_n, event_valid && event_stall, event_valid && $stable(event_kind) && $stable(symbol_char) && $stable(rule_number) && $stable(last_of_run))

	// Once an error is delivered, every later item repeats it.
	`GRT_ASSERT_NXT(a_error_latch, clk, arst_n, ev_take && (event_kind == EV_ERROR), !event_valid || (event_kind == EV_ERROR))

	// Once done is delivered, every later item repeats it.
	`GRT_ASSERT_NXT(a_done_latch, clk, arst_n, ev_take && (event_kind == EV_DONE), !event_valid || (event_kind == EV_DONE))

	// Done and error always close the results of their character; checked while the item is stalled.
	`GRT_ASSERT_IMP(a_final_last, clk, arst_n, ev_held && ((event_kind == EV_ERROR) || (event_kind == EV_DONE)), last_of_run)

	// Only character items carry a character.
	`GRT_ASSERT_IMP(a_char_zero, clk, arst_n, event_valid && no_char, symbol_char == 8'h00)

endmodule

bind grammar_rule_tokenizer_top grt_checker u_grt_checker (.*);
